// ===== hdl/msicc_pkg.sv =====
package msicc_pkg;

	localparam logic [1:0] ST_I = 2'd0;
	localparam logic [1:0] ST_S = 2'd1;
	localparam logic [1:0] ST_M = 2'd2;

	localparam logic [1:0] ACT_PR_RD  = 2'd0;
	localparam logic [1:0] ACT_PR_WR  = 2'd1;
	localparam logic [1:0] ACT_BUS_RD = 2'd2;
	localparam logic [1:0] ACT_BUS_RDX = 2'd3;

	localparam logic [1:0] REQ_NONE  = 2'd0;
	localparam logic [1:0] REQ_BUSRD = 2'd1;
	localparam logic [1:0] REQ_BUSRDX = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] address;
	} req_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] bus_cmd;
		logic       victim_writeback;
		logic       snoop_flush;
		logic       invalidated;
		logic       intervention;
		logic       memory_transaction;
		logic [1:0] new_state;
	} rsp_t;

endpackage

// ===== hdl/msicc_ctrl.sv =====
// sequencer: lookup, victim choice, state update, result register
module msicc_ctrl import msicc_pkg::*; #(
	parameter int NUM_SETS = 64,
	parameter int WAYS = 4,
	parameter int BLOCK_BYTES = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_data
);

	localparam int OFF_W = $clog2(BLOCK_BYTES);
	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int SET_B = $clog2(NUM_SETS);
	localparam int TAG_W = 32 - OFF_W - SET_B;
	localparam int TS_W = TAG_W + 2;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int LINES = NUM_SETS * WAYS;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LOOK = 2'b10
	} fsm_t;

	fsm_t state_q;
	req_t req_q;
	logic [31:0] counter_q;
	logic [LINES-1:0] valid_q;

	// set rows: tag and state of all ways in one memory, stamps in another
	logic [WAYS*TS_W-1:0]  ts_mem  [NUM_SETS];
	logic [WAYS*32-1:0]    stp_mem [NUM_SETS];
	logic [WAYS*TS_W-1:0]  ts_rd_s1;
	logic [WAYS*32-1:0]    stp_rd_s1;

	logic [SET_W-1:0] rd_set, set_q;
	logic [TAG_W-1:0] tag_q;
	logic accept;

	// address split
	always_comb begin
		logic [31:0] blk;
		blk = in_data.address >> OFF_W;
		if (NUM_SETS > 1)
			rd_set = SET_W'(blk);
		else
			rd_set = '0;
	end
	assign set_q = (NUM_SETS > 1) ? SET_W'(req_q.address >> OFF_W) : '0;
	assign tag_q = TAG_W'(req_q.address >> (OFF_W + SET_B));

	assign in_ready = (state_q == S_IDLE) && (!out_valid || out_ready);
	assign accept = in_valid && in_ready;

	// lookup and update decision
	logic [WAYS-1:0] way_v;
	logic [1:0]  cur_st [WAYS];
	logic [31:0] cur_stp [WAYS];
	logic        found;
	logic [WAY_W-1:0] hit_way, vic_way, sel_way;
	logic        any_inv;
	logic [31:0] nxt_cnt;
	logic        do_wr;
	logic [1:0]  wr_st;
	logic        wr_tag, wr_stp;
	rsp_t        rsp;

	always_comb begin
		logic [31:0] low;
		logic pr;
		logic wr;
		nxt_cnt = counter_q + 32'd1;
		found = 1'b0;
		hit_way = '0;
		any_inv = 1'b0;
		vic_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			way_v[w] = valid_q[set_q * WAYS + w];
			cur_st[w] = way_v[w] ? ts_rd_s1[w*TS_W +: 2] : ST_I;
			cur_stp[w] = way_v[w] ? stp_rd_s1[w*32 +: 32] : 32'd0;
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (cur_st[w] != ST_I && ts_rd_s1[w*TS_W + 2 +: TAG_W] == tag_q) begin
				found = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
		low = nxt_cnt - 32'd1;
		for (int w = 0; w < WAYS; w++) begin
			if (cur_stp[w] <= low) begin
				vic_way = WAY_W'(w);
				low = cur_stp[w];
			end
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (cur_st[w] == ST_I) begin
				any_inv = 1'b1;
				vic_way = WAY_W'(w);
			end
		end
		pr = !req_q.action[1];
		wr = (req_q.action == ACT_PR_WR);
		rsp = '0;
		do_wr = 1'b0;
		wr_tag = 1'b0;
		wr_stp = 1'b0;
		sel_way = hit_way;
		wr_st = cur_st[hit_way];
		if (pr) begin
			do_wr = 1'b1;
			wr_stp = 1'b1;
			rsp.memory_transaction = 1'b0;
			if (found) begin
				rsp.hit = 1'b1;
				if (wr && cur_st[hit_way] == ST_S) begin
					wr_st = ST_M;
					rsp.bus_cmd = REQ_BUSRDX;
					rsp.memory_transaction = 1'b1;
				end
			end else begin
				sel_way = vic_way;
				wr_tag = 1'b1;
				rsp.victim_writeback = !any_inv && cur_st[vic_way] == ST_M;
				wr_st = wr ? ST_M : ST_S;
				rsp.bus_cmd = wr ? REQ_BUSRDX : REQ_BUSRD;
				rsp.memory_transaction = 1'b1;
			end
			rsp.new_state = wr_st;
		end else if (found) begin
			do_wr = 1'b1;
			rsp.hit = 1'b1;
			if (req_q.action == ACT_BUS_RDX) begin
				rsp.snoop_flush = cur_st[hit_way] == ST_M;
				rsp.memory_transaction = cur_st[hit_way] == ST_M;
				rsp.invalidated = 1'b1;
				wr_st = ST_I;
			end else if (cur_st[hit_way] == ST_M) begin
				wr_st = ST_S;
				rsp.snoop_flush = 1'b1;
				rsp.intervention = 1'b1;
				rsp.memory_transaction = 1'b1;
			end
			rsp.new_state = wr_st;
		end
	end

	// set memories: registered read, masked write-back of the chosen way
	always_ff @(posedge clk) begin
		ts_rd_s1 <= ts_mem[rd_set];
		stp_rd_s1 <= stp_mem[rd_set];
		if (state_q == S_LOOK && do_wr) begin
			ts_mem[set_q][sel_way*TS_W +: 2] <= wr_st;
			if (wr_tag)
				ts_mem[set_q][sel_way*TS_W + 2 +: TAG_W] <= tag_q;
			if (wr_stp)
				stp_mem[set_q][sel_way*32 +: 32] <= nxt_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_q <= in_data;
		if (state_q == S_LOOK)
			out_data <= rsp;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			counter_q <= '0;
			valid_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_LOOK;
				end
				S_LOOK: begin
					state_q <= S_IDLE;
					out_valid <= 1'b1;
					if (!req_q.action[1])
						counter_q <= nxt_cnt;
					if (do_wr)
						valid_q[set_q * WAYS + sel_way] <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_result_after_look: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOOK |=> out_valid)
		else $error("no result after lookup");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOOK |-> !in_ready)
		else $error("input taken during lookup");
	a_snoop_no_req: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOOK && req_q.action[1] |-> rsp.bus_cmd == REQ_NONE)
		else $error("bus request on snoop");
	a_cnt_snoop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOOK && req_q.action[1] |=> $stable(counter_q))
		else $error("counter moved on snoop");

endmodule

// ===== hdl/msi_snooping_cache_controller.sv =====
// MSI snooping coherence controller, tag and state side of an LRU cache.
// in channel: in_valid/in_ready carry one transaction (action, address);
// out channel: out_valid/out_ready return one result per transaction.
// An accepted transaction reads its set row from memory at the accepting edge,
// then, in the lookup state that follows, compares tags, picks the victim and
// writes the row back; the result is registered as the lookup state ends.
// No new transaction is taken while one is in lookup: in_ready is high only
// in the idle state.
// A waiting result blocks acceptance of the next transaction: in_ready stays
// low until the receiver takes the pending result, so a stalled receiver
// holds the whole block.
// Reset clears all line valid bits (lines read as invalid with zero stamp),
// the access counter and the output valid; tag memory is not cleared.
module msi_snooping_cache_controller import msicc_pkg::*; #(
	parameter int NUM_SETS = 64,
	parameter int WAYS = 4,
	parameter int BLOCK_BYTES = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_data
);

	msicc_ctrl #(
		.NUM_SETS(NUM_SETS),
		.WAYS(WAYS),
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule
